// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/olsah_pkg.sv =====
package olsah_pkg;

    // Open-loop speed to angle-step scaling (right shift of the accumulator).
    localparam int RAMP_SHIFT      = 16;
    // Gap shrink per convergence step, and ticks per step.
    localparam int CONVERGE_STEP   = 9;
    localparam int CONVERGE_PERIOD = 5;

    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 32;
    localparam int CFG_W   = 31;
    localparam int STEP_W  = 3;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_DRAG = 2'd1,
        MODE_RUN  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_RAMP_END = 2'd0,
        REG_RAMP_INC = 2'd1,
        REG_REVERSE  = 2'd2,
        REG_UNUSED   = 2'd3
    } t_reg;

endpackage

// ===== rtl/open_loop_to_sensorless_angle_handoff.sv =====
// Open-loop to sensorless angle handoff.
// One request per control tick on the input channel (i_in_valid / o_in_ready):
// a command (tick, start drag, force run, stop) and the observer's angle.
// Each request yields exactly one result on the output channel
// (o_out_valid / i_out_ready): Park angle, mode, handoff pulse, angle gap.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle unless the output stalls; all tick math
// (32-bit ramp add and compare, 16-bit angle add, gap compare and step) sits
// between the state registers and the single result register.
// Stall: while a result waits, a new request is still taken in the same
// cycle the held result is taken; o_in_ready = output empty or draining.
// Reset (synchronous, active low): idle mode, ramp/angle/gap/step cleared,
// config registers cleared, output empty.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index (0 ramp end,
// 1 ramp increment, 2 reverse); index 3 is ignored. Write only when idle.
module open_loop_to_sensorless_angle_handoff (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [30:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_cmd,
    input  logic signed [15:0]  i_est_angle,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_park_angle,
    output logic [1:0]          o_mode_now,
    output logic                o_handoff_pulse,
    output logic signed [15:0]  o_angle_gap
);

    localparam logic signed [15:0] STEP_POS = 16'(olsah_pkg::CONVERGE_STEP);
    localparam logic signed [15:0] STEP_NEG = -16'(olsah_pkg::CONVERGE_STEP);
    localparam logic [2:0]         PERIOD   = 3'(olsah_pkg::CONVERGE_PERIOD);

    // Configuration registers
    logic [30:0] r_ramp_end;
    logic [30:0] r_ramp_inc;
    logic        r_reverse;

    // Control state
    olsah_pkg::t_mode   r_mode,   n_mode;
    logic [31:0]        r_speed,  n_speed;
    logic [15:0]        r_forced, n_forced;
    logic signed [15:0] r_gap,    n_gap;
    logic [2:0]         r_step,   n_step;

    // Result register
    logic               r_out_valid;
    logic signed [15:0] r_park,   n_park;
    logic [1:0]         r_mode_out;
    logic               r_pulse,  n_pulse;
    logic signed [15:0] r_gap_out;

    logic        accept;
    logic [31:0] speed_sum;
    logic [31:0] speed_shift;
    logic [15:0] delta;
    logic [2:0]  step_inc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign speed_sum   = r_speed + {1'b0, r_ramp_inc};
    assign speed_shift = speed_sum >> olsah_pkg::RAMP_SHIFT;
    assign delta       = speed_shift[15:0];
    assign step_inc    = r_step + 3'd1;

    always_comb begin
        n_mode   = r_mode;
        n_speed  = r_speed;
        n_forced = r_forced;
        n_gap    = r_gap;
        n_step   = r_step;
        n_pulse  = 1'b0;
        n_park   = r_forced;
        case (i_cmd)
            olsah_pkg::CMD_START: begin
                n_mode   = olsah_pkg::MODE_DRAG;
                n_speed  = '0;
                n_forced = '0;
                n_gap    = '0;
                n_step   = '0;
                n_park   = '0;
            end
            olsah_pkg::CMD_STOP: begin
                n_mode   = olsah_pkg::MODE_IDLE;
                n_speed  = '0;
                n_forced = '0;
                n_gap    = '0;
                n_step   = '0;
                n_park   = '0;
            end
            olsah_pkg::CMD_RUN: begin
                n_mode = olsah_pkg::MODE_RUN;
            end
            default: begin
                case (r_mode)
                    olsah_pkg::MODE_DRAG: begin
                        if (r_speed < {1'b0, r_ramp_end}) begin
                            // ramp phase; gap taken from the pre-step angle
                            n_speed = speed_sum;
                            if (speed_sum >= {1'b0, r_ramp_end}) begin
                                n_gap   = r_forced - i_est_angle;
                                n_pulse = 1'b1;
                            end
                            n_forced = r_reverse ? r_forced - delta : r_forced + delta;
                        end else begin
                            // convergence phase
                            if (r_gap > STEP_POS || r_gap < STEP_NEG) begin
                                if (step_inc >= PERIOD) begin
                                    n_gap  = (r_gap < 0) ? r_gap + STEP_POS
                                                         : r_gap - STEP_POS;
                                    n_step = '0;
                                end else begin
                                    n_step = step_inc;
                                end
                            end else begin
                                n_mode = olsah_pkg::MODE_RUN;
                            end
                            n_forced = i_est_angle + n_gap;
                        end
                        n_park = n_forced;
                    end
                    olsah_pkg::MODE_RUN: begin
                        n_forced = i_est_angle;
                        n_park   = i_est_angle;
                    end
                    default: begin
                        n_park = r_forced;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_end <= '0;
            r_ramp_inc <= '0;
            r_reverse  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                olsah_pkg::REG_RAMP_END: r_ramp_end <= i_cfg_data;
                olsah_pkg::REG_RAMP_INC: r_ramp_inc <= i_cfg_data;
                olsah_pkg::REG_REVERSE:  r_reverse  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= olsah_pkg::MODE_IDLE;
            r_speed     <= '0;
            r_forced    <= '0;
            r_gap       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode   <= n_mode;
                r_speed  <= n_speed;
                r_forced <= n_forced;
                r_gap    <= n_gap;
                r_step   <= n_step;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_park     <= n_park;
            r_mode_out <= n_mode;
            r_pulse    <= n_pulse;
            r_gap_out  <= n_gap;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_park_angle    = r_park;
    assign o_mode_now      = r_mode_out;
    assign o_handoff_pulse = r_pulse;
    assign o_angle_gap     = r_gap_out;

endmodule

// ===== rtl/olsah_checker.sv =====
`include "assert_macros.svh"

module olsah_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [1:0]          o_mode_now,
    input logic                o_handoff_pulse,
    input logic signed [15:0]  o_angle_gap
);

    logic in_drag;
    logic in_idle;

    assign in_drag = (o_mode_now == olsah_pkg::MODE_DRAG);
    assign in_idle = (o_mode_now == olsah_pkg::MODE_IDLE);

    // A result left untaken must stay up.
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped")
    // An empty output stage always takes a request.
    `ASSERT_CLK(a_ready_empty, !o_out_valid |-> o_in_ready, "stalled with empty output")
    // Handoff only happens in drag mode.
    `ASSERT_CLK(a_pulse_drag, o_out_valid && o_handoff_pulse |-> in_drag, "handoff outside drag")
    // Idle is reached only by reset or stop, both of which clear the gap.
    `ASSERT_CLK(a_idle_gap, o_out_valid && in_idle |-> o_angle_gap == 16'sd0, "gap left in idle")
    // Reset empties the output stage.
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind open_loop_to_sensorless_angle_handoff olsah_checker u_olsah_checker (.*);

// ===== dv/handoff_checker.sv =====
module handoff_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [olsah_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [1:0]                   i_cmd,
    input  logic signed [15:0]           i_est_angle,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [15:0]           i_park_angle,
    input  logic [1:0]                   i_mode_now,
    input  logic                         i_handoff_pulse,
    input  logic signed [15:0]           i_angle_gap,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct packed {
        logic [olsah_pkg::ANGLE_W-1:0] park;
        olsah_pkg::t_mode              mode;
        logic                          pulse;
        logic [olsah_pkg::ANGLE_W-1:0] gap;
    } t_angle_result;

    // shadow config
    logic [olsah_pkg::CFG_W-1:0]   ramp_end;
    logic [olsah_pkg::CFG_W-1:0]   ramp_inc;
    logic                          reverse;

    // shadow motion state
    olsah_pkg::t_mode              mode_q;
    logic [olsah_pkg::SPEED_W-1:0] speed_acc;
    logic [olsah_pkg::ANGLE_W-1:0] forced_q;
    logic [olsah_pkg::ANGLE_W-1:0] gap_q;
    logic [olsah_pkg::STEP_W-1:0]  step_q;

    t_angle_result      angle_due[$];
    int                 fails = 0;

    function automatic void clear_motion();
        speed_acc = '0;
        forced_q  = '0;
        gap_q     = '0;
        step_q    = '0;
    endfunction

    // One request in, one predicted result out; updates the shadow state.
    function automatic t_angle_result advance_handoff(olsah_pkg::t_cmd cmd,
                                                      logic [olsah_pkg::ANGLE_W-1:0] est);
        t_angle_result                 res;
        logic                          pulse;
        logic [olsah_pkg::ANGLE_W-1:0] delta;
        int                            g;
        int                            mag;
        pulse = 1'b0;
        case (cmd)
            olsah_pkg::CMD_START: begin
                mode_q = olsah_pkg::MODE_DRAG;
                clear_motion();
            end
            olsah_pkg::CMD_RUN: begin
                mode_q = olsah_pkg::MODE_RUN;
            end
            olsah_pkg::CMD_STOP: begin
                mode_q = olsah_pkg::MODE_IDLE;
                clear_motion();
            end
            default: begin
                if (mode_q == olsah_pkg::MODE_DRAG) begin
                    if (speed_acc < {1'b0, ramp_end}) begin
                        speed_acc = speed_acc + {1'b0, ramp_inc};
                        // gap taken before this tick's step
                        if (speed_acc >= {1'b0, ramp_end}) begin
                            gap_q = forced_q - est;
                            pulse = 1'b1;
                        end
                        delta    = 16'(speed_acc >> olsah_pkg::RAMP_SHIFT);
                        forced_q = reverse ? forced_q - delta : forced_q + delta;
                    end else begin
                        g   = int'($signed(gap_q));
                        mag = (g < 0) ? -g : g;
                        if (mag > olsah_pkg::CONVERGE_STEP) begin
                            step_q = step_q + 1'b1;
                            if (step_q >= olsah_pkg::CONVERGE_PERIOD) begin
                                g      = (g < 0) ? g + olsah_pkg::CONVERGE_STEP
                                                 : g - olsah_pkg::CONVERGE_STEP;
                                gap_q  = 16'(g);
                                step_q = '0;
                            end
                        end else begin
                            mode_q = olsah_pkg::MODE_RUN;
                        end
                        forced_q = est + gap_q;
                    end
                end else if (mode_q == olsah_pkg::MODE_RUN) begin
                    forced_q = est;
                end
            end
        endcase
        // park angle is the forced angle after the request in every mode
        res.park  = forced_q;
        res.mode  = mode_q;
        res.pulse = pulse;
        res.gap   = gap_q;
        return res;
    endfunction

    function automatic void check_field(string field, logic signed [31:0] want_v,
                                        logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_angle_result want;
        if (!i_rst_n) begin
            ramp_end = '0;
            ramp_inc = '0;
            reverse  = 1'b0;
            mode_q   = olsah_pkg::MODE_IDLE;
            clear_motion();
            angle_due.delete();
        end else begin
            // retire first: a result never belongs to a request of the same edge
            if (i_out_valid && i_out_ready) begin
                if (angle_due.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    want = angle_due.pop_front();
                    check_field("park_angle", $signed(want.park), i_park_angle);
                    check_field("mode_now", want.mode, i_mode_now);
                    check_field("handoff_pulse", want.pulse, i_handoff_pulse);
                    check_field("angle_gap", $signed(want.gap), i_angle_gap);
                end
            end
            if (i_cfg_we) begin
                case (olsah_pkg::t_reg'(i_cfg_index))
                    olsah_pkg::REG_RAMP_END: ramp_end = i_cfg_data;
                    olsah_pkg::REG_RAMP_INC: ramp_inc = i_cfg_data;
                    olsah_pkg::REG_REVERSE:  reverse  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                angle_due.push_back(advance_handoff(olsah_pkg::t_cmd'(i_cmd), i_est_angle));
        end
        o_pending    <= angle_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the handoff regression. It only makes stimulus and gives the
// verdict; handoff_checker beside the block tracks the config, predicts every
// result and compares. All block inputs move by nonblocking assignment at the
// rising edge, so the checker and the block both see pre-edge values.
module testbench;

    typedef logic [olsah_pkg::CFG_W-1:0] t_cfg;

    // cycles with no request or result moving before we call it hung
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BUDGET = 78;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    t_cfg               cfg_data = '0;
    logic               in_valid = 1'b0;
    olsah_pkg::t_cmd    cmd_drv = olsah_pkg::CMD_TICK;
    logic signed [15:0] est_drv = '0;
    logic               out_ready = 1'b1;
    // set for a stretch with no idling on either side
    logic               no_stall = 1'b0;

    logic               in_ready;
    logic               out_valid;
    logic signed [15:0] park_angle;
    logic [1:0]         mode_now;
    logic               handoff_pulse;
    logic signed [15:0] angle_gap;
    int                 fail_count;
    int                 pending;

    open_loop_to_sensorless_angle_handoff u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_cmd           (cmd_drv),
        .i_est_angle     (est_drv),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_park_angle    (park_angle),
        .o_mode_now      (mode_now),
        .o_handoff_pulse (handoff_pulse),
        .o_angle_gap     (angle_gap)
    );

    handoff_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_cmd           (cmd_drv),
        .i_est_angle     (est_drv),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_park_angle    (park_angle),
        .i_mode_now      (mode_now),
        .i_handoff_pulse (handoff_pulse),
        .i_angle_gap     (angle_gap),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: back-pressure about 22% of cycles unless in a quiet stretch.
    always @(posedge i_clk) begin
        out_ready <= no_stall || ($urandom_range(0, 99) >= 22);
    end

    // Idle the request side for a random number of cycles after an acceptance.
    task automatic pause_sender();
        while (!no_stall && $urandom_range(0, 99) < 22) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Present one request and hold it until taken. Valid is left high so a
    // back-to-back request needs no lower/raise in the same step.
    task automatic send_request(olsah_pkg::t_cmd c, logic [15:0] e);
        in_valid <= 1'b1;
        cmd_drv  <= c;
        est_drv  <= e;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        pause_sender();
    endtask

    // Hold off requests until every predicted result has come back,
    // then let the result register drain.
    task automatic settle_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(olsah_pkg::t_reg idx, t_cfg val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Only called with the block idle. The unused index gets junk to show it
    // is ignored; upper bits of the direction word are junk too.
    task automatic program_regs(t_cfg end_spd, t_cfg inc_spd, logic rev);
        write_reg(olsah_pkg::REG_RAMP_END, end_spd);
        write_reg(olsah_pkg::REG_RAMP_INC, inc_spd);
        write_reg(olsah_pkg::REG_REVERSE, (t_cfg'($urandom) & ~t_cfg'(1)) | t_cfg'(rev));
        write_reg(olsah_pkg::REG_UNUSED, t_cfg'($urandom));
        cfg_we <= 1'b0;
    endtask

    // A drag sequence: start, then ticks. Gentle phases keep the estimate near
    // zero so the captured gap is small and convergence finishes in reach.
    // A few requests are random commands to break the sequence.
    task automatic run_sequence(int ticks, bit gentle);
        send_request(olsah_pkg::CMD_START, 16'($urandom));
        repeat (ticks) begin
            if ($urandom_range(0, 99) < 8)
                send_request(olsah_pkg::t_cmd'($urandom_range(0, 3)), 16'($urandom));
            else if (gentle)
                send_request(olsah_pkg::CMD_TICK, 16'(int'($urandom_range(0, 128)) - 64));
            else
                send_request(olsah_pkg::CMD_TICK, 16'($urandom));
        end
    endtask

    // Random config for a phase. Gentle: speed stays under one angle LSB so
    // the forced angle holds at zero. Wide: full range, a few corners.
    task automatic pick_config(bit gentle);
        t_cfg end_spd;
        t_cfg inc_spd;
        if (gentle) begin
            end_spd = t_cfg'($urandom_range(0, 'h8000));
            inc_spd = t_cfg'($urandom_range(1, 'h8000));
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    end_spd = '1;
                    inc_spd = '1;
                end
                1: begin
                    end_spd = '0;
                    inc_spd = t_cfg'($urandom);
                end
                2: begin
                    // ramp never ends
                    end_spd = t_cfg'($urandom) | t_cfg'(1);
                    inc_spd = '0;
                end
                default: begin
                    end_spd = t_cfg'($urandom);
                    inc_spd = (end_spd >> $urandom_range(0, 3)) | t_cfg'(1);
                end
            endcase
        end
        program_regs(end_spd, inc_spd, 1'($urandom));
    endtask

    initial begin : stimulus
        int budget;
        int len;
        bit gentle;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset config (all zero): idle ticks hold the angle, force run,
        // run ticks follow the estimate, stop, then a drag with ramp end of
        // zero that goes to run on its first tick.
        send_request(olsah_pkg::CMD_TICK, 16'sh7FFF);
        send_request(olsah_pkg::CMD_TICK, 16'sh8000);
        send_request(olsah_pkg::CMD_RUN, 16'h1234);
        send_request(olsah_pkg::CMD_TICK, 16'sh8000);
        send_request(olsah_pkg::CMD_TICK, 16'sh7FFF);
        send_request(olsah_pkg::CMD_STOP, 16'h5555);
        send_request(olsah_pkg::CMD_START, 16'hAAAA);
        send_request(olsah_pkg::CMD_TICK, 16'h0100);
        send_request(olsah_pkg::CMD_TICK, 16'hFFFF);
        settle_results();

        // Extremes, reverse: ramp ends on the first tick with the largest
        // step, gap near full scale, then convergence steps at the period.
        program_regs('1, '1, 1'b1);
        send_request(olsah_pkg::CMD_START, 16'h0000);
        send_request(olsah_pkg::CMD_TICK, 16'sh7FFF);
        repeat (6) send_request(olsah_pkg::CMD_TICK, 16'sh8000);
        send_request(olsah_pkg::CMD_RUN, 16'h0000);
        send_request(olsah_pkg::CMD_TICK, 16'h1357);
        send_request(olsah_pkg::CMD_STOP, 16'h0000);
        settle_results();

        // Three-tick ramp forward, small gap: converges on the next tick.
        program_regs(t_cfg'('h30000), t_cfg'('h10000), 1'b0);
        send_request(olsah_pkg::CMD_START, 16'h0000);
        repeat (5) send_request(olsah_pkg::CMD_TICK, 16'h0000);

        // Random phases; each one drains first so config writes land idle.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_results();
            gentle = (phase % 3) != 2;
            pick_config(gentle);
            if (phase == 3)
                no_stall <= 1'b1;
            else if (phase == 5)
                no_stall <= 1'b0;
            budget = PHASE_BUDGET;
            while (budget > 0) begin
                len = $urandom_range(4, 48);
                run_sequence(len, gentle);
                budget -= len + 1;
            end
        end

        settle_results();
        if (fail_count == 0 && pending == 0)
            $display("open_loop_to_sensorless_angle_handoff regression: pass");
        else
            $display("open_loop_to_sensorless_angle_handoff regression: fail");
        $finish;
    end

    // Watchdog: any request or result moving resets the count.
    initial begin : watchdog
        int stale;
        stale = 0;
        while (stale < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stale = 0;
            else
                stale++;
        end
        $display("open_loop_to_sensorless_angle_handoff regression: fail");
        $finish;
    end

endmodule
